[hdl/cad_pkg.sv]
// Package: types, constants and functions shared by the CashAddr decoder.
`timescale 1ns / 1ps
package cad_pkg;

  localparam int PREFIX_LIMIT_DEF = 32;
  localparam int MAX_PAYLOAD_BYTES_DEF = 100;
  localparam int STORE_DEPTH = 21;
  localparam int DIGEST_LEN = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [39:0] GEN0 = 40'h98f2bc8e61;
  localparam logic [39:0] GEN1 = 40'h79b76d99e2;
  localparam logic [39:0] GEN2 = 40'hf33e5fb3c4;
  localparam logic [39:0] GEN3 = 40'hae2eabe2a8;
  localparam logic [39:0] GEN4 = 40'h1e4f43e470;
  localparam logic [39:0] LOW_MASK = 40'h07ffffffff;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_END = 8'h00;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PREFIX_LONG = 3'd1,
    ST_BAD_CHAR    = 3'd2,
    ST_SHORT       = 3'd3,
    ST_BAD_CSUM    = 3'd4,
    ST_BAD_PAYLOAD = 3'd5,
    ST_PAY_SHORT   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_PREFIX = 2'd0,
    CMD_COLON  = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       bad;
    logic [4:0] sym;
    logic [4:0] low5;
  } cmd_item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_EMIT
  } back_state_t;

  function automatic logic [39:0] poly_step(input logic [39:0] c, input logic [4:0] d);
    logic [4:0] top;
    logic [39:0] r;
    top = c[39:35];
    r = ((c & LOW_MASK) << 5) ^ {35'd0, d};
    if (top[0]) r = r ^ GEN0;
    if (top[1]) r = r ^ GEN1;
    if (top[2]) r = r ^ GEN2;
    if (top[3]) r = r ^ GEN3;
    if (top[4]) r = r ^ GEN4;
    return r;
  endfunction

  function automatic logic [5:0] symbol_of(input logic [7:0] ch);
    logic [7:0] c;
    logic [5:0] r;
    c = ch;
    r = 6'd32;
    if (ch >= 8'h41 && ch <= 8'h5a) c = ch + 8'd32;
    case (c)
      "q": r = 6'd0;  "p": r = 6'd1;  "z": r = 6'd2;  "r": r = 6'd3;
      "y": r = 6'd4;  "9": r = 6'd5;  "x": r = 6'd6;  "8": r = 6'd7;
      "g": r = 6'd8;  "f": r = 6'd9;  "2": r = 6'd10; "t": r = 6'd11;
      "v": r = 6'd12; "d": r = 6'd13; "w": r = 6'd14; "0": r = 6'd15;
      "s": r = 6'd16; "3": r = 6'd17; "j": r = 6'd18; "n": r = 6'd19;
      "5": r = 6'd20; "4": r = 6'd21; "k": r = 6'd22; "h": r = 6'd23;
      "c": r = 6'd24; "e": r = 6'd25; "6": r = 6'd26; "m": r = 6'd27;
      "u": r = 6'd28; "a": r = 6'd29; "7": r = 6'd30; "l": r = 6'd31;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

  // polymod of "bitcoincash" then a zero separator, started at 1
  function automatic logic [39:0] default_main();
    logic [39:0] c;
    c = 40'd1;
    c = poly_step(c, 5'(8'h62)); c = poly_step(c, 5'(8'h69));
    c = poly_step(c, 5'(8'h74)); c = poly_step(c, 5'(8'h63));
    c = poly_step(c, 5'(8'h6f)); c = poly_step(c, 5'(8'h69));
    c = poly_step(c, 5'(8'h6e)); c = poly_step(c, 5'(8'h63));
    c = poly_step(c, 5'(8'h61)); c = poly_step(c, 5'(8'h73));
    c = poly_step(c, 5'(8'h68)); c = poly_step(c, 5'd0);
    return c;
  endfunction

endpackage

[hdl/cad_front.sv]
// Front part: accepts characters, classifies them and queues commands.
`timescale 1ns / 1ps
module cad_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_code,
  output logic                q_valid,
  input  logic                q_pop,
  output cad_pkg::cmd_item_t  q_item
);
  import cad_pkg::*;

  cmd_item_t  buf_r [QUEUE_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       colon_r, colon_nxt;
  logic       push;
  cmd_item_t  item;
  logic [5:0] s;

  assign in_stall = (cnt_r == 2'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rp_r];

  always_comb begin
    s = symbol_of(in_char_code);
    item.sym = s[4:0];
    item.bad = s[5];
    item.low5 = in_char_code[4:0];
    if (in_char_code == CH_END) item.cmd = CMD_END;
    else if (!colon_r && in_char_code == CH_COLON) item.cmd = CMD_COLON;
    else if (!colon_r) item.cmd = CMD_PREFIX;
    else item.cmd = CMD_SYMBOL;
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    colon_nxt = colon_r;
    if (push) begin
      if (in_char_code == CH_END) colon_nxt = 1'b0;
      else if (in_char_code == CH_COLON) colon_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      colon_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
      colon_r <= colon_nxt;
    end
    if (push) buf_r[wp_r] <= item;
  end
endmodule

[hdl/cad_back.sv]
// Back part: checksum runs, symbol delay, byte unpacking and result output.
`timescale 1ns / 1ps
module cad_back #(
  parameter int PREFIX_LIMIT = cad_pkg::PREFIX_LIMIT_DEF,
  parameter int MAX_PAYLOAD_BYTES = cad_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  cad_pkg::cmd_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [2:0]         out_version,
  output logic [1:0]         out_type_code,
  output logic [7:0]         out_hash_byte,
  output logic [4:0]         out_byte_index,
  output logic               out_last
);
  import cad_pkg::*;

  back_state_t st_r, st_nxt;
  logic [39:0] main_r, main_nxt, pre_r, pre_nxt;
  logic [6:0]  pcnt_r, pcnt_nxt;
  logic        colon_r, colon_nxt, bad_r, bad_nxt;
  logic [7:0]  scnt_r, scnt_nxt;
  logic [4:0]  dly_r [8];
  logic [11:0] bbuf_r, bbuf_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic [6:0]  bytec_r, bytec_nxt;
  logic [7:0]  store_r [STORE_DEPTH];
  logic [2:0]  stat_r, stat_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        shift_en, unpack_en, byte_done;
  logic [11:0] nb;
  logic [3:0]  nbc;
  logic [7:0]  new_byte;
  logic [4:0]  tb;

  always_comb begin
    st_nxt = st_r;
    main_nxt = main_r; pre_nxt = pre_r; pcnt_nxt = pcnt_r;
    colon_nxt = colon_r; bad_nxt = bad_r; scnt_nxt = scnt_r;
    bbuf_nxt = bbuf_r; bcnt_nxt = bcnt_r; bytec_nxt = bytec_r;
    stat_nxt = stat_r; idx_nxt = idx_r;
    q_pop = 1'b0; shift_en = 1'b0; unpack_en = 1'b0; byte_done = 1'b0;
    nb = {bbuf_r[6:0], dly_r[0]};
    nbc = bcnt_r + 4'd5;
    new_byte = 8'(nb >> (nbc - 4'd8));
    unique case (st_r)
      BK_RUN: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.cmd)
            CMD_COLON: begin
              colon_nxt = 1'b1;
              main_nxt = poly_step(pre_r, 5'd0);
              bad_nxt = 1'b0; scnt_nxt = 8'd0; bbuf_nxt = 12'd0;
              bcnt_nxt = 4'd0; bytec_nxt = 7'd0;
            end
            CMD_PREFIX, CMD_SYMBOL: begin
              if (q_item.cmd == CMD_PREFIX) begin
                pre_nxt = poly_step(pre_r, q_item.low5);
                if (pcnt_r != 7'd127) pcnt_nxt = pcnt_r + 7'd1;
              end
              if (q_item.bad) bad_nxt = 1'b1;
              else begin
                main_nxt = poly_step(main_r, q_item.sym);
                shift_en = 1'b1;
                if (scnt_r != 8'd255) scnt_nxt = scnt_r + 8'd1;
                if (scnt_r >= 8'd8) begin
                  unpack_en = 1'b1;
                  if (nbc >= 4'd8) begin
                    byte_done = 1'b1;
                    bcnt_nxt = nbc - 4'd8;
                    bbuf_nxt = nb & ((12'd1 << (nbc - 4'd8)) - 12'd1);
                    if (bytec_r <= 7'(MAX_PAYLOAD_BYTES)) bytec_nxt = bytec_r + 7'd1;
                  end else begin
                    bcnt_nxt = nbc;
                    bbuf_nxt = nb;
                  end
                end
              end
            end
            CMD_END: begin
              if (colon_r && pcnt_r >= 7'(PREFIX_LIMIT)) stat_nxt = ST_PREFIX_LONG;
              else if (bad_r) stat_nxt = ST_BAD_CHAR;
              else if (scnt_r < 8'd8) stat_nxt = ST_SHORT;
              else if (main_r != 40'd1) stat_nxt = ST_BAD_CSUM;
              else if (bytec_r == 7'd0 || bytec_r > 7'(MAX_PAYLOAD_BYTES))
                stat_nxt = ST_BAD_PAYLOAD;
              else if (bytec_r < 7'(STORE_DEPTH)) stat_nxt = ST_PAY_SHORT;
              else stat_nxt = ST_OK;
              idx_nxt = 5'd0;
              st_nxt = BK_EMIT;
            end
            default: ;
          endcase
        end
      end
      BK_EMIT: begin
        if (!out_stall) begin
          if (stat_r != ST_OK || idx_r == 5'(DIGEST_LEN - 1)) begin
            st_nxt = BK_RUN;
            main_nxt = default_main(); pre_nxt = 40'd1; pcnt_nxt = 7'd0;
            colon_nxt = 1'b0; bad_nxt = 1'b0; scnt_nxt = 8'd0;
            bbuf_nxt = 12'd0; bcnt_nxt = 4'd0; bytec_nxt = 7'd0;
          end else idx_nxt = idx_r + 5'd1;
        end
      end
      default: st_nxt = BK_RUN;
    endcase
  end

  assign tb = store_r[0][7:3];
  assign out_valid = (st_r == BK_EMIT);
  assign out_status = stat_r;
  assign out_version = (stat_r == ST_OK) ? store_r[0][2:0] : 3'd0;
  assign out_type_code = (stat_r != ST_OK) ? 2'd0 :
                         (tb == 5'd0) ? 2'd0 : (tb == 5'd1) ? 2'd1 : 2'd2;
  assign out_hash_byte = (stat_r == ST_OK) ? store_r[idx_r + 5'd1] : 8'd0;
  assign out_byte_index = (stat_r == ST_OK) ? idx_r : 5'd0;
  assign out_last = (stat_r != ST_OK) || (idx_r == 5'(DIGEST_LEN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_RUN;
      main_r <= default_main(); pre_r <= 40'd1; pcnt_r <= 7'd0;
      colon_r <= 1'b0; bad_r <= 1'b0; scnt_r <= 8'd0;
      bbuf_r <= 12'd0; bcnt_r <= 4'd0; bytec_r <= 7'd0;
      stat_r <= ST_OK; idx_r <= 5'd0;
    end else begin
      st_r <= st_nxt;
      main_r <= main_nxt; pre_r <= pre_nxt; pcnt_r <= pcnt_nxt;
      colon_r <= colon_nxt; bad_r <= bad_nxt; scnt_r <= scnt_nxt;
      bbuf_r <= bbuf_nxt; bcnt_r <= bcnt_nxt; bytec_r <= bytec_nxt;
      stat_r <= stat_nxt; idx_r <= idx_nxt;
    end
    if (shift_en) begin
      for (int i = 0; i < 7; i++) dly_r[i] <= dly_r[i + 1];
      dly_r[7] <= q_item.sym;
    end
    if (unpack_en && byte_done && bytec_r < 7'(STORE_DEPTH))
      store_r[bytec_r[4:0]] <= new_byte;
  end
endmodule

[hdl/cashaddr_decoder_core.sv]
// Top level: CashAddr base32 decoder with BCH polymod check.
// Flow: characters are queued in registers; the end code moves the back part to BK_EMIT.
// Throughput: one character per cycle; the end code emits 1 or 20 results, one per
//   cycle unless out_stall; once the two-entry queue is full, input stalls as they drain.
// Reset: synchronous active-low rst_n restores the default-prefix checksum and clears
//   counters and flags; the delay line and byte store are not cleared.
`timescale 1ns / 1ps
module cashaddr_decoder_core #(
  parameter int PREFIX_LIMIT = cad_pkg::PREFIX_LIMIT_DEF,
  parameter int MAX_PAYLOAD_BYTES = cad_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [2:0] out_version,
  output logic [1:0] out_type_code,
  output logic [7:0] out_hash_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last
);
  import cad_pkg::*;

  logic      q_valid, q_pop;
  cmd_item_t q_item;

  cad_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_code,
    .q_valid, .q_pop, .q_item
  );

  cad_back #(.PREFIX_LIMIT(PREFIX_LIMIT), .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .out_valid, .out_stall, .out_status, .out_version, .out_type_code,
    .out_hash_byte, .out_byte_index, .out_last
  );

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last) else $error("error result not last");
  a_idx_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_byte_index != 5'd0)
    else $error("hash sequence broken");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
endmodule
